// ===== src/range_sample_qualifier_macros.svh =====
// ----------------------------------------------------------------------------
// Range sample qualifier assertion macros
// Shared concurrent assertion forms for the qualifier RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_SAMPLE_QUALIFIER_MACROS_SVH
`define RANGE_SAMPLE_QUALIFIER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RSQ_ASSERT_IMPLIES(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RSQ_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Range sample qualifier package
// Status codes, register map and reset values of the qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsq_pkg;

    localparam int unsigned DIST_W   = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CODE_W   = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SAMPLE = 2'd1,
        ST_TIMEOUT   = 2'd2,
        ST_OUT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MIN_VALID_MM      = 2'd0,
        REG_MAX_VALID_MM      = 2'd1,
        REG_TIMEOUT_THRESHOLD = 2'd2,
        REG_VALID_RANGE_CODE  = 2'd3
    } reg_idx_t;

    localparam logic [DIST_W-1:0]  MIN_VALID_MM_RST      = 16'd15;
    localparam logic [DIST_W-1:0]  MAX_VALID_MM_RST      = 16'd2000;
    localparam logic [COUNT_W-1:0] TIMEOUT_THRESHOLD_RST = 8'd3;
    localparam logic [CODE_W-1:0]  VALID_RANGE_CODE_RST  = 4'd11;

    localparam logic [COUNT_W-1:0] MISS_COUNT_MAX = 8'hFF;

    // Ready flags sit in the low three bits of the interrupt status byte.
    localparam logic [7:0] IRQ_READY_MASK = 8'h07;

endpackage

`default_nettype wire

// ===== src/range_sample_qualifier.sv =====
// ----------------------------------------------------------------------------
// Range sample qualifier
// Qualifies polls of a time-of-flight ranging sensor, tracks missed polls
// and holds the last good distance.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------------
//  in        in_valid / in_stall     poll_ok, interrupt_status, meas_status,
//                                    range_mm
//  out       out_valid / out_stall   distance_mm, sample_status
//  cfg       APB psel/penable/...    pwdata[31:0] at paddr 0x0,0x4,0x8,0xC
//
//  Each poll gives one result beat: the poll is first held in the input register,
//  then passes through the qualify logic into the result register.
//  One poll is accepted every clock while the result side keeps up.
//  A stall on the output holds the result register and then the input
//  register; in_stall rises only when both are full.
//  Reset clears the held distance, the miss counter and the pipeline valids,
//  and loads the configuration registers with their default values.
//
`timescale 1ns / 1ps
`default_nettype none

`include "range_sample_qualifier_macros.svh"

module range_sample_qualifier (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        poll_ok,
    input  wire logic [7:0]                  interrupt_status,
    input  wire logic [7:0]                  meas_status,
    input  wire logic [rsq_pkg::DIST_W-1:0]  range_mm,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [rsq_pkg::DIST_W-1:0]       distance_mm,
    output logic [1:0]                       sample_status,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rsq_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rsq_pkg::DATA_W-1:0]  pwdata,
    output logic [rsq_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    import rsq_pkg::*;

    // Configuration registers.
    logic [DIST_W-1:0]  min_valid_mm_reg;
    logic [DIST_W-1:0]  max_valid_mm_reg;
    logic [COUNT_W-1:0] timeout_threshold_reg;
    logic [CODE_W-1:0]  valid_range_code_reg;

    // Input stage.
    logic               in_valid_reg;
    logic               poll_ok_reg;
    logic [7:0]         irq_reg;
    logic [7:0]         rstat_reg;
    logic [DIST_W-1:0]  range_mm_reg;

    // Qualifier state.
    logic [DIST_W-1:0]  held_distance_reg;
    logic [DIST_W-1:0]  held_distance_next;
    logic [COUNT_W-1:0] miss_count_reg;
    logic [COUNT_W-1:0] miss_count_next;

    // Result stage.
    logic               out_valid_reg;
    logic [DIST_W-1:0]  distance_reg;
    logic [DIST_W-1:0]  distance_next;
    status_t            status_reg;
    status_t            status_next;

    logic               in_take;
    logic               advance;
    logic               cfg_write;
    reg_idx_t           cfg_idx;
    logic               is_miss;
    logic [CODE_W-1:0]  dev_code;
    logic               sample_good;

    logic               chk_ok;
    logic               chk_miss;
    logic               chk_sample;
    logic               held_match;
    logic               miss_zero;

    assign in_take   = in_valid && !in_stall;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;

    assign out_valid     = out_valid_reg;
    assign distance_mm   = distance_reg;
    assign sample_status = status_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_MIN_VALID_MM:      prdata = {{(DATA_W-DIST_W){1'b0}}, min_valid_mm_reg};
            REG_MAX_VALID_MM:      prdata = {{(DATA_W-DIST_W){1'b0}}, max_valid_mm_reg};
            REG_TIMEOUT_THRESHOLD: prdata = {{(DATA_W-COUNT_W){1'b0}}, timeout_threshold_reg};
            REG_VALID_RANGE_CODE:  prdata = {{(DATA_W-CODE_W){1'b0}}, valid_range_code_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_mm_reg      <= MIN_VALID_MM_RST;
            max_valid_mm_reg      <= MAX_VALID_MM_RST;
            timeout_threshold_reg <= TIMEOUT_THRESHOLD_RST;
            valid_range_code_reg  <= VALID_RANGE_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MIN_VALID_MM:      min_valid_mm_reg      <= pwdata[DIST_W-1:0];
                REG_MAX_VALID_MM:      max_valid_mm_reg      <= pwdata[DIST_W-1:0];
                REG_TIMEOUT_THRESHOLD: timeout_threshold_reg <= pwdata[COUNT_W-1:0];
                REG_VALID_RANGE_CODE:  valid_range_code_reg  <= pwdata[CODE_W-1:0];
                default:               ;
            endcase
        end
    end

    // Qualify the poll held in the input register.
    always_comb
    begin
        is_miss     = !poll_ok_reg || ((irq_reg & IRQ_READY_MASK) == 8'h00);
        dev_code    = rstat_reg[6:3];
        sample_good = (dev_code == valid_range_code_reg)
                      && (range_mm_reg >= min_valid_mm_reg)
                      && (range_mm_reg <= max_valid_mm_reg);

        held_distance_next = held_distance_reg;
        miss_count_next    = miss_count_reg;
        distance_next      = held_distance_reg;
        status_next        = ST_OUT_RANGE;

        if (is_miss)
        begin
            if (miss_count_reg != MISS_COUNT_MAX)
            begin
                miss_count_next = miss_count_reg + COUNT_W'(1);
            end
            status_next = (miss_count_next >= timeout_threshold_reg) ? ST_TIMEOUT
                                                                     : ST_NO_SAMPLE;
        end
        else
        begin
            miss_count_next = '0;
            if (sample_good)
            begin
                held_distance_next = range_mm_reg;
                distance_next      = range_mm_reg;
                status_next        = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            held_distance_reg <= '0;
            miss_count_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                held_distance_reg <= held_distance_next;
                miss_count_reg    <= miss_count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_ok_reg  <= poll_ok;
            irq_reg      <= interrupt_status;
            rstat_reg    <= meas_status;
            range_mm_reg <= range_mm;
        end
        if (advance)
        begin
            distance_reg <= distance_next;
            status_reg   <= status_next;
        end
    end

    assign chk_ok     = out_valid_reg && (status_reg == ST_OK);
    assign chk_miss   = out_valid_reg
                        && (status_reg == ST_NO_SAMPLE || status_reg == ST_TIMEOUT);
    assign chk_sample = out_valid_reg
                        && (status_reg == ST_OK || status_reg == ST_OUT_RANGE);
    assign held_match = (distance_reg == held_distance_reg);
    assign miss_zero  = (miss_count_reg == '0);

    // A pending result always matches the state its poll left behind.
    `RSQ_ASSERT_IMPLIES(a_ok_matches_held, clk, rst_n, chk_ok, held_match, "ok beat lost held")
    `RSQ_ASSERT_IMPLIES(a_miss_counted, clk, rst_n, chk_miss, !miss_zero, "miss with zero count")
    `RSQ_ASSERT_IMPLIES(a_sample_clears, clk, rst_n, chk_sample, miss_zero, "sample kept misses")
    `RSQ_ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid_reg, "poll gave no result")

endmodule

`default_nettype wire
